// ----- src/mandelbrot_column_renderer_core_macros.svh -----
// assertion macros used by the checker file
`ifndef MANDELBROT_COLUMN_RENDERER_CORE_MACROS_SVH
`define MANDELBROT_COLUMN_RENDERER_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MCR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/mcr_pkg.sv -----
// shared constants and types of the mandelbrot column renderer
package mcr_pkg;

	// field widths
	localparam int COL_W      = 7;
	localparam int PAGE_W     = 3;
	localparam int BITS_W     = 8;
	localparam int ZOOM_W     = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// fixed-point format of the center registers
	localparam int REG_FRAC = 28;

	// signed pixel offset width, covers column and row offsets
	localparam int OFS_W = 10;

	// eight rows per page, one lane each
	localparam int LANES  = 8;
	localparam int STEP_W = 4;
	localparam int KIDX_W = 3;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// iteration limits
	localparam int LIM_W = 6;
	typedef logic [LIM_W-1:0] limit_t;
	localparam limit_t LIMIT_LO  = limit_t'(20);
	localparam limit_t LIMIT_MID = limit_t'(30);
	localparam limit_t LIMIT_HI  = limit_t'(40);

	localparam logic [ZOOM_W-1:0] ZOOM_LO_MAX = 5'd7;
	localparam logic [ZOOM_W-1:0] ZOOM_MID    = 5'd8;
	localparam logic [ZOOM_W-1:0] ZOOM_RESET  = 5'd5;

	// escape bound |z|^2 > 4
	localparam int ESC_BOUND = 4;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_RE  = 2'd0,
		REG_CENTER_IM  = 2'd1,
		REG_ZOOM_SHIFT = 2'd2
	} cfg_reg_t;

	// lane control from the back sequencer
	typedef struct packed {
		logic load;
		logic step;
	} lane_ctl_t;

endpackage

// ----- src/mcr_front.sv -----
// front: accepts a request, works out the nine point coordinates, picks the limit
module mcr_front #(
	parameter int WIDTH     = 128,
	parameter int HEIGHT    = 64,
	parameter int FRAC_BITS = 28
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    push,
	output logic                                    full,
	input  logic [mcr_pkg::COL_W-1:0]               column,
	input  logic [mcr_pkg::PAGE_W-1:0]              page,
	input  logic signed [mcr_pkg::CFG_DATA_W-1:0]   center_re,
	input  logic signed [mcr_pkg::CFG_DATA_W-1:0]   center_im,
	input  logic [mcr_pkg::ZOOM_W-1:0]              zoom_shift,
	output logic                                    q_push,
	input  logic                                    q_full,
	output logic [mcr_pkg::LIM_W+(mcr_pkg::LANES+1)*(FRAC_BITS+4)-1:0] q_data
);

	localparam int W  = FRAC_BITS + 4;
	localparam int XW = W + mcr_pkg::OFS_W;
	localparam int CW = W + mcr_pkg::CFG_DATA_W;
	localparam int LS = (FRAC_BITS >= mcr_pkg::REG_FRAC) ? FRAC_BITS - mcr_pkg::REG_FRAC : 0;
	localparam int RS = (FRAC_BITS >= mcr_pkg::REG_FRAC) ? 0 : mcr_pkg::REG_FRAC - FRAC_BITS;
	localparam logic signed [XW-1:0] WMAX_X = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [XW-1:0] WMIN_X = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic signed [W-1:0]  WMAX   = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0]  WMIN   = {1'b1, {(W-1){1'b0}}};

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_CALC,
		FR_PUSH
	} fr_state_t;

	fr_state_t                      state_q;
	logic [mcr_pkg::STEP_W-1:0]     step_q;
	logic [mcr_pkg::COL_W-1:0]      col_q;
	logic [mcr_pkg::PAGE_W-1:0]     page_q;
	logic signed [W-1:0]            cr_q;
	logic signed [W-1:0]            ci_q [mcr_pkg::LANES];

	logic [mcr_pkg::KIDX_W-1:0]     kidx;
	logic signed [CW-1:0]           cre_x, cim_x;
	logic signed [W-1:0]            cre_w, cim_w, cen_mux;
	logic signed [mcr_pkg::OFS_W-1:0] d_mux;
	logic signed [XW-1:0]           d_ext, d_shl, d_shr;
	logic [6:0]                     lsh, rsh;
	logic                           use_left;
	logic signed [W-1:0]            off, coord;
	logic signed [W:0]              coord_sum;
	mcr_pkg::limit_t                limit;

	assign full   = (state_q != FR_IDLE);
	assign q_push = (state_q == FR_PUSH) && !q_full;
	assign kidx   = mcr_pkg::KIDX_W'(step_q - mcr_pkg::STEP_W'(1));

	// centers to the internal format
	always_comb begin
		cre_x = (CW'(center_re) <<< LS) >>> RS;
		cim_x = (CW'(center_im) <<< LS) >>> RS;
		cre_w = cre_x[W-1:0];
		cim_w = cim_x[W-1:0];
	end

	// pixel offset for the current step: real first, then the eight rows
	always_comb begin
		if (step_q == '0) begin
			cen_mux = cre_w;
			d_mux   = $signed({3'b0, col_q}) - mcr_pkg::OFS_W'(WIDTH / 2);
		end else begin
			cen_mux = cim_w;
			d_mux   = $signed({4'b0, page_q, kidx}) - mcr_pkg::OFS_W'(HEIGHT / 2);
		end
	end

	// scaled offset plus center, saturating
	always_comb begin
		use_left = ({2'b0, zoom_shift} <= 7'(FRAC_BITS));
		lsh      = 7'(FRAC_BITS) - {2'b0, zoom_shift};
		rsh      = {2'b0, zoom_shift} - 7'(FRAC_BITS);
		d_ext    = XW'(d_mux);
		d_shl    = d_ext <<< lsh;
		d_shr    = d_ext >>> rsh;
		if (use_left) begin
			if (d_shl > WMAX_X) begin
				off = WMAX;
			end else if (d_shl < WMIN_X) begin
				off = WMIN;
			end else begin
				off = d_shl[W-1:0];
			end
		end else begin
			off = d_shr[W-1:0];
		end
		coord_sum = {cen_mux[W-1], cen_mux} + {off[W-1], off};
		if (coord_sum[W] != coord_sum[W-1]) begin
			coord = coord_sum[W] ? WMIN : WMAX;
		end else begin
			coord = coord_sum[W-1:0];
		end
	end

	// iteration limit from the zoom
	always_comb begin
		if (zoom_shift <= mcr_pkg::ZOOM_LO_MAX) begin
			limit = mcr_pkg::LIMIT_LO;
		end else if (zoom_shift == mcr_pkg::ZOOM_MID) begin
			limit = mcr_pkg::LIMIT_MID;
		end else begin
			limit = mcr_pkg::LIMIT_HI;
		end
	end

	// queue entry: limit, real part, imaginary parts by row
	always_comb begin
		q_data[mcr_pkg::LANES*W +: W] = cr_q;
		q_data[(mcr_pkg::LANES+1)*W +: mcr_pkg::LIM_W] = limit;
		for (int k = 0; k < mcr_pkg::LANES; k++) begin
			q_data[k*W +: W] = ci_q[k];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				FR_IDLE: begin
					if (push) begin
						state_q <= FR_CALC;
						step_q  <= '0;
					end
				end
				FR_CALC: begin
					if (step_q == mcr_pkg::STEP_W'(mcr_pkg::LANES)) begin
						state_q <= FR_PUSH;
					end else begin
						step_q <= step_q + mcr_pkg::STEP_W'(1);
					end
				end
				FR_PUSH: begin
					if (!q_full) begin
						state_q <= FR_IDLE;
					end
				end
				default: begin
					state_q <= FR_IDLE;
				end
			endcase
		end
	end

	// request and coordinate payload
	always_ff @(posedge clk) begin
		if (state_q == FR_IDLE && push) begin
			col_q  <= column;
			page_q <= page;
		end
		if (state_q == FR_CALC) begin
			if (step_q == '0) begin
				cr_q <= coord;
			end else begin
				ci_q[kidx] <= coord;
			end
		end
	end

endmodule

// ----- src/mcr_queue.sv -----
// small register queue between front and back
module mcr_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] wdata,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] rdata,
	output logic              empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ----- src/mcr_lane.sv -----
// one iteration lane: z = z^2 + c with saturation and escape test
module mcr_lane #(
	parameter int FRAC_BITS = 28
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mcr_pkg::lane_ctl_t        ctl,
	input  logic signed [FRAC_BITS+3:0] cr,
	input  logic signed [FRAC_BITS+3:0] ci,
	output logic                      active
);

	localparam int W = FRAC_BITS + 4;
	localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [2*W-1:0] MAG_NEG_LIM = (2*W)'(1) << (W - 1);
	localparam logic [2*W-1:0] MAG_POS_LIM = MAG_NEG_LIM - (2*W)'(1);
	localparam logic [W:0]     BOUND = (W+1)'(mcr_pkg::ESC_BOUND) << FRAC_BITS;

	// product truncated toward zero, then saturated
	function automatic logic signed [W-1:0] mul_q(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic           neg;
		logic [W-1:0]   ma, mb;
		logic [2*W-1:0] mp, mag;
		logic [W-1:0]   mlo;
		neg = a[W-1] ^ b[W-1];
		ma  = a[W-1] ? (~$unsigned(a) + W'(1)) : $unsigned(a);
		mb  = b[W-1] ? (~$unsigned(b) + W'(1)) : $unsigned(b);
		mp  = (2*W)'(ma) * (2*W)'(mb);
		mag = mp >> FRAC_BITS;
		mlo = mag[W-1:0];
		if (neg) begin
			mul_q = (mag > MAG_NEG_LIM) ? WMIN : $signed(~mlo + W'(1));
		end else begin
			mul_q = (mag > MAG_POS_LIM) ? WMAX : $signed(mlo);
		end
	endfunction

	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) begin
			sat_add = s[W] ? WMIN : WMAX;
		end else begin
			sat_add = s[W-1:0];
		end
	endfunction

	logic signed [W-1:0] zr_q, zi_q, cr_q, ci_q;
	logic                active_q;
	logic signed [W-1:0] r2, i2, t, zr_nxt, zi_nxt;
	logic [W:0]          mag2;
	logic                escape;

	assign active = active_q;

	// one iteration step
	always_comb begin
		r2     = mul_q(zr_q, zr_q);
		i2     = mul_q(zi_q, zi_q);
		t      = mul_q(zr_q, zi_q);
		mag2   = {1'b0, $unsigned(r2)} + {1'b0, $unsigned(i2)};
		escape = (mag2 > BOUND);
		zi_nxt = sat_add(sat_add(t, t), ci_q);
		zr_nxt = sat_add(sat_add(r2, -i2), cr_q);
	end

	// lane activity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (ctl.load) begin
			active_q <= 1'b1;
		end else if (ctl.step && active_q && escape) begin
			active_q <= 1'b0;
		end
	end

	// point and orbit
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cr_q <= cr;
			ci_q <= ci;
			zr_q <= '0;
			zi_q <= '0;
		end else if (ctl.step && active_q && !escape) begin
			zr_q <= zr_nxt;
			zi_q <= zi_nxt;
		end
	end

endmodule

// ----- src/mcr_back.sv -----
// back: eight lanes iterate one column of points, result into the output register
module mcr_back #(
	parameter int FRAC_BITS = 28
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [mcr_pkg::LIM_W+(mcr_pkg::LANES+1)*(FRAC_BITS+4)-1:0] q_data,
	input  logic                              q_empty,
	output logic                              q_pop,
	output logic                              out_valid,
	output logic [mcr_pkg::BITS_W-1:0]        out_bits,
	input  logic                              pop
);

	localparam int W = FRAC_BITS + 4;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} bk_state_t;

	bk_state_t                   state_q;
	mcr_pkg::limit_t             count_q, limit_q;
	logic                        out_valid_q;
	logic [mcr_pkg::BITS_W-1:0]  out_bits_q;
	logic [mcr_pkg::LANES-1:0]   active;
	mcr_pkg::lane_ctl_t          lane_ctl;
	logic                        finish, slot_free, deliver;

	assign out_valid      = out_valid_q;
	assign out_bits       = out_bits_q;
	assign finish         = (count_q == limit_q) || (active == '0);
	assign slot_free      = !out_valid_q || pop;
	assign deliver        = (state_q == BK_RUN) && finish && slot_free;
	assign q_pop          = (state_q == BK_IDLE) && !q_empty;
	assign lane_ctl.load  = q_pop;
	assign lane_ctl.step  = (state_q == BK_RUN) && !finish;

	// lanes, one per row of the page
	for (genvar k = 0; k < mcr_pkg::LANES; k++) begin : g_lane
		mcr_lane #(
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (lane_ctl),
			.cr    (q_data[mcr_pkg::LANES*W +: W]),
			.ci    (q_data[k*W +: W]),
			.active(active[k])
		);
	end

	// iteration sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			count_q     <= '0;
			limit_q     <= '0;
			out_valid_q <= 1'b0;
			out_bits_q  <= '0;
		end else begin
			if (deliver) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					if (!q_empty) begin
						limit_q <= q_data[(mcr_pkg::LANES+1)*W +: mcr_pkg::LIM_W];
						count_q <= '0;
						state_q <= BK_RUN;
					end
				end
				BK_RUN: begin
					if (!finish) begin
						count_q <= count_q + mcr_pkg::LIM_W'(1);
					end else if (slot_free) begin
						out_bits_q  <= active;
						state_q     <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/mandelbrot_column_renderer_core.sv -----
// the front works out the coordinates, then the back iterates up to the limit (20/30/40 by zoom)
// the eight iteration lanes share one step count; a column ends early when all eight points escape,
//   and the front overlaps the next request while the back takes one column at a time
// reset: arst_n clears all control state and the queue, center to 0 and zoom_shift to 5
// top level: configuration registers, front, queue, back
module mandelbrot_column_renderer_core #(
	parameter int WIDTH     = 128,
	parameter int HEIGHT    = 64,
	parameter int FRAC_BITS = 28
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	output logic                               full,
	input  logic [mcr_pkg::COL_W-1:0]          column,
	input  logic [mcr_pkg::PAGE_W-1:0]         page,
	output logic                               empty,
	input  logic                               pop,
	output logic [mcr_pkg::BITS_W-1:0]         column_bits,
	input  logic                               cfg_write,
	input  logic [mcr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mcr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int W       = FRAC_BITS + 4;
	localparam int ENTRY_W = mcr_pkg::LIM_W + (mcr_pkg::LANES + 1) * W;

	logic signed [mcr_pkg::CFG_DATA_W-1:0] center_re_q, center_im_q;
	logic [mcr_pkg::ZOOM_W-1:0]            zoom_shift_q;
	logic                                  q_push, q_full, q_pop, q_empty, out_valid;
	logic [ENTRY_W-1:0]                    q_wdata, q_rdata;

	assign empty = !out_valid;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_re_q  <= '0;
			center_im_q  <= '0;
			zoom_shift_q <= mcr_pkg::ZOOM_RESET;
		end else if (cfg_write) begin
			case (mcr_pkg::cfg_reg_t'(cfg_index))
				mcr_pkg::REG_CENTER_RE:  center_re_q  <= $signed(cfg_data);
				mcr_pkg::REG_CENTER_IM:  center_im_q  <= $signed(cfg_data);
				mcr_pkg::REG_ZOOM_SHIFT: zoom_shift_q <= cfg_data[mcr_pkg::ZOOM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// request intake and coordinates
	mcr_front #(
		.WIDTH    (WIDTH),
		.HEIGHT   (HEIGHT),
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.column    (column),
		.page      (page),
		.center_re (center_re_q),
		.center_im (center_im_q),
		.zoom_shift(zoom_shift_q),
		.q_push    (q_push),
		.q_full    (q_full),
		.q_data    (q_wdata)
	);

	// decoupling queue
	mcr_queue #(
		.DATA_W(ENTRY_W),
		.DEPTH (mcr_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	// iteration lanes and result
	mcr_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_data   (q_rdata),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_bits (column_bits),
		.pop      (pop)
	);

endmodule

// ----- src/mcr_checker.sv -----
// port-level assertions for the renderer core, bound to the top level
`include "mandelbrot_column_renderer_core_macros.svh"

module mcr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        push,
	input logic                        full,
	input logic                        empty,
	input logic                        pop,
	input logic [mcr_pkg::BITS_W-1:0]  column_bits
);

	// an accepted request keeps the front busy
	`MCR_ASSERT_NEXT(a_busy_after_request, clk, arst_n, push && !full, full, "front not busy after request")

	// the front is still busy at the last coordinate step
	`MCR_ASSERT_IMPLY(a_busy_coord_steps, clk, arst_n, push && !full, ##9 full, "front freed during coordinate steps")

	// a waiting result holds until taken
	`MCR_ASSERT_NEXT(a_result_held, clk, arst_n, !empty && !pop, !empty && $stable(column_bits), "waiting result changed or lost")

endmodule

bind mandelbrot_column_renderer_core mcr_checker u_mcr_checker (.*);
